FILE: design/ddoc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddoc_pkg
// Shared types, codes and the operation program of the odometry block.
// ---------------------------------------------------------------------------
package ddoc_pkg;

  // Rotation steps and widths of the fixed-point units
  localparam int CORDIC_STEPS = 24;
  localparam int CORD_CNT_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int DIV_W        = 56;
  localparam int DIV_CNT_W    = $clog2(DIV_W);

  localparam logic [63:0] BAM_PER_RAD  = 64'd683565276;
  localparam logic [33:0] CORDIC_START = 34'd652032874;

  // Configuration register indexes
  localparam logic [1:0] REG_WHEEL_BASE = 2'd0;
  localparam logic [1:0] REG_RIGHT_GAIN = 2'd1;
  localparam logic [1:0] REG_LEFT_GAIN  = 2'd2;

  // Operation kinds
  localparam logic [1:0] KIND_MUL    = 2'd0;
  localparam logic [1:0] KIND_DIV    = 2'd1;
  localparam logic [1:0] KIND_CORDIC = 2'd2;

  // Operand sources
  localparam logic [4:0] SRC_SUM   = 5'd0;
  localparam logic [4:0] SRC_ADIFF = 5'd1;
  localparam logic [4:0] SRC_BAM   = 5'd2;
  localparam logic [4:0] SRC_C     = 5'd3;
  localparam logic [4:0] SRC_S     = 5'd4;
  localparam logic [4:0] SRC_A     = 5'd5;
  localparam logic [4:0] SRC_BB    = 5'd6;
  localparam logic [4:0] SRC_AA    = 5'd7;
  localparam logic [4:0] SRC_AB    = 5'd8;
  localparam logic [4:0] SRC_B2    = 5'd9;
  localparam logic [4:0] SRC_U     = 5'd10;
  localparam logic [4:0] SRC_P2    = 5'd11;
  localparam logic [4:0] SRC_P4    = 5'd12;
  localparam logic [4:0] SRC_P5    = 5'd13;
  localparam logic [4:0] SRC_G0X   = 5'd14;
  localparam logic [4:0] SRC_G0Y   = 5'd15;
  localparam logic [4:0] SRC_G0H   = 5'd16;
  localparam logic [4:0] SRC_G1X   = 5'd17;
  localparam logic [4:0] SRC_G1Y   = 5'd18;
  localparam logic [4:0] SRC_G1H   = 5'd19;
  localparam logic [4:0] SRC_QN0   = 5'd20;
  localparam logic [4:0] SRC_QN1   = 5'd21;
  localparam logic [4:0] SRC_T     = 5'd22;
  localparam logic [4:0] SRC_RG    = 5'd23;
  localparam logic [4:0] SRC_LG    = 5'd24;
  localparam logic [4:0] SRC_ADR   = 5'd25;
  localparam logic [4:0] SRC_ADL   = 5'd26;

  // Result destinations
  localparam logic [4:0] DST_TMP = 5'd0;
  localparam logic [4:0] DST_Q2  = 5'd1;
  localparam logic [4:0] DST_DX  = 5'd2;
  localparam logic [4:0] DST_DY  = 5'd3;
  localparam logic [4:0] DST_AA  = 5'd4;
  localparam logic [4:0] DST_AB  = 5'd5;
  localparam logic [4:0] DST_B2  = 5'd6;
  localparam logic [4:0] DST_U   = 5'd7;
  localparam logic [4:0] DST_IB  = 5'd8;
  localparam logic [4:0] DST_SU  = 5'd9;
  localparam logic [4:0] DST_CU  = 5'd10;
  localparam logic [4:0] DST_QN0 = 5'd11;
  localparam logic [4:0] DST_QN1 = 5'd12;
  localparam logic [4:0] DST_T   = 5'd13;
  localparam logic [4:0] DST_CS  = 5'd14;
  localparam logic [4:0] DST_N0  = 5'd15;
  localparam logic [4:0] DST_N1  = 5'd16;
  localparam logic [4:0] DST_N2  = 5'd17;
  localparam logic [4:0] DST_N3  = 5'd18;
  localparam logic [4:0] DST_N4  = 5'd19;
  localparam logic [4:0] DST_N5  = 5'd20;

  localparam int NUM_OPS = 47;
  localparam int PC_W    = $clog2(NUM_OPS);

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic [5:0] shamt;
    logic [4:0] dst;
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  function automatic op_t mk(input logic [1:0] kind, input logic [4:0] sa,
                             input logic [4:0] sb, input logic [5:0] sh,
                             input logic [4:0] dst);
    op_t o;
    o.kind  = kind;
    o.src_a = sa;
    o.src_b = sb;
    o.shamt = sh;
    o.dst   = dst;
    return o;
  endfunction

  // Operation program for one item
  function automatic op_t prog_op(input logic [PC_W-1:0] pc);
    op_t o;
    case (pc)
      6'd0:  o = mk(KIND_MUL, SRC_ADIFF, SRC_BAM, 6'd0, DST_TMP);
      6'd1:  o = mk(KIND_DIV, SRC_SUM, SRC_SUM, 6'd0, DST_Q2);
      6'd2:  o = mk(KIND_CORDIC, SRC_SUM, SRC_SUM, 6'd0, DST_CS);
      6'd3:  o = mk(KIND_MUL, SRC_SUM, SRC_C, 6'd31, DST_DX);
      6'd4:  o = mk(KIND_MUL, SRC_SUM, SRC_S, 6'd31, DST_DY);
      6'd5:  o = mk(KIND_MUL, SRC_A, SRC_A, 6'd0, DST_AA);
      6'd6:  o = mk(KIND_MUL, SRC_A, SRC_BB, 6'd0, DST_AB);
      6'd7:  o = mk(KIND_MUL, SRC_BB, SRC_BB, 6'd0, DST_B2);
      6'd8:  o = mk(KIND_DIV, SRC_SUM, SRC_SUM, 6'd0, DST_U);
      6'd9:  o = mk(KIND_DIV, SRC_SUM, SRC_SUM, 6'd0, DST_IB);
      6'd10: o = mk(KIND_MUL, SRC_S, SRC_U, 6'd30, DST_SU);
      6'd11: o = mk(KIND_MUL, SRC_C, SRC_U, 6'd30, DST_CU);
      6'd12: o = mk(KIND_MUL, SRC_RG, SRC_ADR, 6'd0, DST_QN0);
      6'd13: o = mk(KIND_MUL, SRC_LG, SRC_ADL, 6'd0, DST_QN1);
      6'd14: o = mk(KIND_MUL, SRC_A, SRC_P2, 6'd15, DST_N0);
      6'd15: o = mk(KIND_MUL, SRC_AA, SRC_P5, 6'd32, DST_N0);
      6'd16: o = mk(KIND_MUL, SRC_A, SRC_P4, 6'd16, DST_N1);
      6'd17: o = mk(KIND_MUL, SRC_BB, SRC_P2, 6'd16, DST_N1);
      6'd18: o = mk(KIND_MUL, SRC_AB, SRC_P5, 6'd32, DST_N1);
      6'd19: o = mk(KIND_MUL, SRC_A, SRC_P5, 6'd16, DST_N2);
      6'd20: o = mk(KIND_MUL, SRC_BB, SRC_P4, 6'd15, DST_N3);
      6'd21: o = mk(KIND_MUL, SRC_B2, SRC_P5, 6'd32, DST_N3);
      6'd22: o = mk(KIND_MUL, SRC_BB, SRC_P5, 6'd16, DST_N4);
      // right wheel noise
      6'd23: o = mk(KIND_MUL, SRC_G0X, SRC_G0X, 6'd30, DST_T);
      6'd24: o = mk(KIND_MUL, SRC_QN0, SRC_T, 6'd30, DST_N0);
      6'd25: o = mk(KIND_MUL, SRC_G0X, SRC_G0Y, 6'd30, DST_T);
      6'd26: o = mk(KIND_MUL, SRC_QN0, SRC_T, 6'd30, DST_N1);
      6'd27: o = mk(KIND_MUL, SRC_G0X, SRC_G0H, 6'd30, DST_T);
      6'd28: o = mk(KIND_MUL, SRC_QN0, SRC_T, 6'd30, DST_N2);
      6'd29: o = mk(KIND_MUL, SRC_G0Y, SRC_G0Y, 6'd30, DST_T);
      6'd30: o = mk(KIND_MUL, SRC_QN0, SRC_T, 6'd30, DST_N3);
      6'd31: o = mk(KIND_MUL, SRC_G0Y, SRC_G0H, 6'd30, DST_T);
      6'd32: o = mk(KIND_MUL, SRC_QN0, SRC_T, 6'd30, DST_N4);
      6'd33: o = mk(KIND_MUL, SRC_G0H, SRC_G0H, 6'd30, DST_T);
      6'd34: o = mk(KIND_MUL, SRC_QN0, SRC_T, 6'd30, DST_N5);
      // left wheel noise
      6'd35: o = mk(KIND_MUL, SRC_G1X, SRC_G1X, 6'd30, DST_T);
      6'd36: o = mk(KIND_MUL, SRC_QN1, SRC_T, 6'd30, DST_N0);
      6'd37: o = mk(KIND_MUL, SRC_G1X, SRC_G1Y, 6'd30, DST_T);
      6'd38: o = mk(KIND_MUL, SRC_QN1, SRC_T, 6'd30, DST_N1);
      6'd39: o = mk(KIND_MUL, SRC_G1X, SRC_G1H, 6'd30, DST_T);
      6'd40: o = mk(KIND_MUL, SRC_QN1, SRC_T, 6'd30, DST_N2);
      6'd41: o = mk(KIND_MUL, SRC_G1Y, SRC_G1Y, 6'd30, DST_T);
      6'd42: o = mk(KIND_MUL, SRC_QN1, SRC_T, 6'd30, DST_N3);
      6'd43: o = mk(KIND_MUL, SRC_G1Y, SRC_G1H, 6'd30, DST_T);
      6'd44: o = mk(KIND_MUL, SRC_QN1, SRC_T, 6'd30, DST_N4);
      6'd45: o = mk(KIND_MUL, SRC_G1H, SRC_G1H, 6'd30, DST_T);
      6'd46: o = mk(KIND_MUL, SRC_QN1, SRC_T, 6'd30, DST_N5);
      default: o = mk(KIND_MUL, SRC_ADIFF, SRC_BAM, 6'd0, DST_TMP);
    endcase
    return o;
  endfunction

  // Arctangent of 2^-i in binary-angle units
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_007F_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[39:0];
    if (v < lo) return lo[39:0];
    return v[39:0];
  endfunction

endpackage

FILE: design/diff_drive_odometry_covariance_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_drive_odometry_covariance_top
// Differential-drive odometry with 3x3 pose covariance propagation.
//
//   channel  dir  width  contents
//   s_*      in   48     left_travel, right_travel
//   m_*      out  400    pose_x, pose_y, heading, var_xx..var_hh
//   cfg_*    in   24     wheel_base, right_noise_gain, left_noise_gain
//
// An item is accepted, then worked through 43 passes of the shared
// multiplier (four 32x32 partial products plus rounding each), three
// divisions (56 quotient bits each), the CORDIC rotation and a commit.
// Reset is synchronous; pose, heading and covariance clear to zero.
// One item is worked at a time; a new item is taken while the last result
// waits in the output register, and commit stalls until that one is taken.
// ---------------------------------------------------------------------------
module diff_drive_odometry_covariance_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // left_travel[23:0], right_travel[47:24]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [399:0] m_tdata,   // pose_x, pose_y, heading, var_xx, var_xy,
                                  // var_xh, var_yy, var_yh, var_hh
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import ddoc_pkg::*;

  cmd_t    cmd;
  status_t status;

  ddoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ddoc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: design/ddoc_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddoc_mul
// Shared signed multiplier: 64x64 as four 32x32 partial products, then a
// rounded shift (ties away from zero) with the result limited to 2^60.
// ---------------------------------------------------------------------------
module ddoc_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         shamt,
  output logic               done,
  output logic signed [63:0] prod
);
  import ddoc_pkg::*;

  localparam logic [127:0] TERM_LIM = 128'd1 << 60;

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [5:0]   shr;
  logic [63:0]  preg;
  logic [1:0]   preg_sh;
  logic [127:0] acc;

  logic [31:0]  sel_a;
  logic [31:0]  sel_b;
  logic [63:0]  pp;
  logic [127:0] rnd;
  logic [127:0] rsum;
  logic [127:0] rq;
  logic [63:0]  mag;

  // Pick the partial product for this step
  assign sel_a = cnt[1] ? ma[63:32] : ma[31:0];
  assign sel_b = cnt[0] ? mb[63:32] : mb[31:0];
  assign pp    = {32'd0, sel_a} * {32'd0, sel_b};

  // Round, shift and limit the full product
  assign rnd  = (shr == 6'd0) ? 128'd0 : (128'd1 << (shr - 6'd1));
  assign rsum = acc + rnd;
  assign rq   = rsum >> shr;
  assign mag  = (rq > TERM_LIM) ? TERM_LIM[63:0] : rq[63:0];

  // Step through the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        acc  <= 128'd0;
        ma   <= a[63] ? 64'(-a) : 64'(a);
        mb   <= b[63] ? 64'(-b) : 64'(b);
        neg  <= a[63] ^ b[63];
        shr  <= shamt;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt <= 3'd3) begin
          preg    <= pp;
          preg_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt >= 3'd1 && cnt <= 3'd4) begin
          acc <= acc + (128'(preg) << {preg_sh, 5'd0});
        end
        if (cnt == 3'd5) begin
          prod <= neg ? -$signed(mag) : $signed(mag);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: design/ddoc_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddoc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ddoc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ddoc_pkg::DIV_W-1:0]   num,
  input  logic [23:0]                  den,
  output logic                         done,
  output logic [ddoc_pkg::DIV_W-1:0]   quo
);
  import ddoc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [23:0]          dreg;
  logic [23:0]          rem;
  logic [24:0]          trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dreg};

  // Shift in one dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= 24'd0;
        dreg <= den;
        quo  <= num;
      end else if (busy) begin
        rem <= fits ? 24'(trial - {1'b0, dreg}) : trial[23:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/ddoc_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddoc_dpath
// Pose and covariance datapath: operand registers, CORDIC rotator, shared
// multiplier and divider, configuration and state registers.
// ---------------------------------------------------------------------------
module ddoc_dpath (
  input  logic              clk,
  input  logic              rst,
  input  logic [47:0]       s_tdata,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  ddoc_pkg::cmd_t    cmd,
  output ddoc_pkg::status_t status,
  output logic [399:0]      m_tdata
);
  import ddoc_pkg::*;

  // Configuration
  logic [23:0] wheel_base;
  logic [23:0] right_gain;
  logic [23:0] left_gain;

  // Pose and covariance state
  logic signed [39:0] pos_x;
  logic signed [39:0] pos_y;
  logic [31:0]        head;
  logic signed [47:0] cov [6];

  // Working registers of one item
  logic signed [23:0] dl;
  logic signed [23:0] dr;
  logic [DIV_W-1:0]   tmp;
  logic [DIV_W-1:0]   q2;
  logic signed [63:0] c, s, dx, dy, aa, ab, b2, u, ib, su, cu, qn0, qn1, t;
  logic signed [63:0] n [6];

  // CORDIC rotator
  logic                  cord_busy;
  logic                  cord_fin;
  logic [CORD_CNT_W-1:0] cord_cnt;
  logic signed [33:0]    cx, cy, cz;
  logic [1:0]            quad;

  // Derived values
  logic signed [24:0] sum, diff;
  logic [24:0]        abs_sum, abs_diff, abs_dr, abs_dl;
  logic [23:0]        bdiv;
  logic [31:0]        dth, hth, ang, ang_off, res;
  logic signed [63:0] a_neg, ch, sh, g0x, g0y, g1x, g1y;
  logic signed [63:0] val_a, val_b;
  logic signed [33:0] xs, ys, at;
  logic [DIV_W-1:0]   half_b, div_num, div_quo;
  logic               div_done, mul_done;
  logic signed [63:0] mul_prod;
  logic               mul_go, div_go, cord_go;

  assign sum      = 25'(dl) + 25'(dr);
  assign diff     = 25'(dr) - 25'(dl);
  assign abs_sum  = sum[24] ? 25'(-sum) : 25'(sum);
  assign abs_diff = diff[24] ? 25'(-diff) : 25'(diff);
  assign abs_dr   = dr[23] ? 25'(-25'(dr)) : 25'(dr);
  assign abs_dl   = dl[23] ? 25'(-25'(dl)) : 25'(dl);
  assign bdiv     = (wheel_base == 24'd0) ? 24'd1 : wheel_base;
  assign half_b   = DIV_W'(bdiv >> 1);

  // Heading step and mid-step heading
  assign dth = diff[24] ? -q2[31:0] : q2[31:0];
  assign hth = diff[24] ? -q2[32:1] : q2[32:1];
  assign ang = head + hth;

  // Jacobian terms
  assign a_neg = -dy;
  assign ch    = c >>> 1;
  assign sh    = s >>> 1;
  assign g0x   = ch - su;
  assign g0y   = sh + cu;
  assign g1x   = ch + su;
  assign g1y   = sh - cu;

  function automatic logic signed [63:0] pick(input logic [4:0] sel);
    logic signed [63:0] v;
    case (sel)
      SRC_SUM:   v = 64'(sum);
      SRC_ADIFF: v = $signed(64'(abs_diff));
      SRC_BAM:   v = $signed(BAM_PER_RAD);
      SRC_C:     v = c;
      SRC_S:     v = s;
      SRC_A:     v = a_neg;
      SRC_BB:    v = dx;
      SRC_AA:    v = aa;
      SRC_AB:    v = ab;
      SRC_B2:    v = b2;
      SRC_U:     v = u;
      SRC_P2:    v = 64'(cov[2]);
      SRC_P4:    v = 64'(cov[4]);
      SRC_P5:    v = 64'(cov[5]);
      SRC_G0X:   v = g0x;
      SRC_G0Y:   v = g0y;
      SRC_G0H:   v = ib;
      SRC_G1X:   v = g1x;
      SRC_G1Y:   v = g1y;
      SRC_G1H:   v = -ib;
      SRC_QN0:   v = qn0;
      SRC_QN1:   v = qn1;
      SRC_T:     v = t;
      SRC_RG:    v = $signed(64'(right_gain));
      SRC_LG:    v = $signed(64'(left_gain));
      SRC_ADR:   v = $signed(64'(abs_dr));
      SRC_ADL:   v = $signed(64'(abs_dl));
      default:   v = 64'sd0;
    endcase
    return v;
  endfunction

  always_comb begin
    val_a = pick(cmd.op.src_a);
    val_b = pick(cmd.op.src_b);
  end

  // Dividend for each division
  always_comb begin
    case (cmd.op.dst)
      DST_Q2:  div_num = tmp + half_b;
      DST_U:   div_num = (DIV_W'(abs_sum) << 28) + half_b;
      default: div_num = (DIV_W'(1) << 46) + half_b;
    endcase
  end

  assign mul_go  = cmd.start && (cmd.op.kind == KIND_MUL);
  assign div_go  = cmd.start && (cmd.op.kind == KIND_DIV);
  assign cord_go = cmd.start && (cmd.op.kind == KIND_CORDIC);

  ddoc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (val_a),
    .b     (val_b),
    .shamt (cmd.op.shamt),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ddoc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (bdiv),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign status.done = mul_done | div_done | cord_fin;

  // CORDIC step terms and quadrant fold
  assign xs      = cx >>> cord_cnt;
  assign ys      = cy >>> cord_cnt;
  assign at      = $signed({2'b00, atan_bam(5'(cord_cnt))});
  assign ang_off = ang + 32'h2000_0000;
  assign res     = ang - {ang_off[31:30], 30'd0};

  // Rotate toward the residual angle, one step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cord_busy <= 1'b0;
      cord_fin  <= 1'b0;
    end else begin
      cord_fin <= 1'b0;
      if (cord_go) begin
        cord_busy <= 1'b1;
        cord_cnt  <= '0;
        quad      <= ang_off[31:30];
        cx        <= $signed(CORDIC_START);
        cy        <= 34'sd0;
        cz        <= 34'($signed(res));
      end else if (cord_busy) begin
        if (!cz[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
        cord_cnt <= cord_cnt + 1'b1;
        if (cord_cnt == CORD_CNT_W'(CORDIC_STEPS - 1)) begin
          cord_busy <= 1'b0;
          cord_fin  <= 1'b1;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base <= 24'd65536;
      right_gain <= 24'd65536;
      left_gain  <= 24'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WHEEL_BASE: wheel_base <= cfg_data;
        REG_RIGHT_GAIN: right_gain <= cfg_data;
        REG_LEFT_GAIN:  left_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load the item, capture unit results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dl <= $signed(s_tdata[23:0]);
      dr <= $signed(s_tdata[47:24]);
      for (int e = 0; e < 6; e++) begin
        n[e] <= 64'(cov[e]);
      end
    end
    if (cord_fin) begin
      case (quad)
        2'd0: begin c <= 64'(cx);  s <= 64'(cy);  end
        2'd1: begin c <= -64'(cy); s <= 64'(cx);  end
        2'd2: begin c <= -64'(cx); s <= -64'(cy); end
        default: begin c <= 64'(cy); s <= -64'(cx); end
      endcase
    end
    if (div_done) begin
      case (cmd.op.dst)
        DST_Q2:  q2 <= div_quo;
        DST_U:   u  <= sum[24] ? -$signed(64'(div_quo)) : $signed(64'(div_quo));
        default: ib <= $signed(64'(div_quo));
      endcase
    end
    if (mul_done) begin
      case (cmd.op.dst)
        DST_TMP: tmp <= mul_prod[DIV_W-1:0];
        DST_DX:  dx  <= mul_prod;
        DST_DY:  dy  <= mul_prod;
        DST_AA:  aa  <= mul_prod;
        DST_AB:  ab  <= mul_prod;
        DST_B2:  b2  <= mul_prod;
        DST_SU:  su  <= mul_prod;
        DST_CU:  cu  <= mul_prod;
        DST_QN0: qn0 <= mul_prod;
        DST_QN1: qn1 <= mul_prod;
        DST_T:   t   <= mul_prod;
        DST_N0:  n[0] <= n[0] + mul_prod;
        DST_N1:  n[1] <= n[1] + mul_prod;
        DST_N2:  n[2] <= n[2] + mul_prod;
        DST_N3:  n[3] <= n[3] + mul_prod;
        DST_N4:  n[4] <= n[4] + mul_prod;
        DST_N5:  n[5] <= n[5] + mul_prod;
        default: ;
      endcase
    end
  end

  // Commit the new pose and covariance
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= 40'sd0;
      pos_y <= 40'sd0;
      head  <= 32'd0;
      for (int e = 0; e < 6; e++) begin
        cov[e] <= 48'sd0;
      end
    end else if (cmd.finish) begin
      pos_x <= sat40(64'(pos_x) + dx);
      pos_y <= sat40(64'(pos_y) + dy);
      head  <= head + dth;
      for (int e = 0; e < 6; e++) begin
        cov[e] <= sat48(n[e]);
      end
    end
  end

  assign m_tdata = {cov[5], cov[4], cov[3], cov[2], cov[1], cov[0], head, pos_y, pos_x};

endmodule

FILE: design/ddoc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddoc_ctrl
// Sequencer: accepts an item, steps the datapath through the operation
// program, then commits the result into the output register.
// ---------------------------------------------------------------------------
module ddoc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output ddoc_pkg::cmd_t    cmd,
  input  ddoc_pkg::status_t status
);
  import ddoc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            last_op;

  assign s_tready   = (state == ST_IDLE);
  assign last_op    = (pc == PC_W'(NUM_OPS - 1));
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.start  = (state == ST_ISSUE);
  assign cmd.finish = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign cmd.op     = prog_op(pc);

  // Next state
  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_ISSUE;
          pc_next    = '0;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (status.done) begin
          if (last_op) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ISSUE;
            pc_next    = pc + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (cmd.finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_issues: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_ISSUE)
    else $error("accepted item did not start the program");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result committed over a waiting result");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> pc < PC_W'(NUM_OPS))
    else $error("program counter out of range");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == ST_WAIT)
    else $error("unit finished outside of a wait");
`endif

endmodule
